/* hw/rtl/slfp_pkg.sv */
// ----------------------------------------------------------------------------
// slfp_pkg: shared types and constants of the sync/length frame parser
// Field widths, register indexes and reset values, the parser phases, the
// item formats between the stages, and the CRC-16 (reflected 0xA001) step.
// ----------------------------------------------------------------------------
package slfp_pkg;

   localparam int BYTE_W      = 8;
   localparam int WORD_W      = 16;
   localparam int STATUS_W    = 2;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   // Depth of each short queue; keep it a power of two so pointers wrap.
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [WORD_W-1:0] CRC_POLY = 16'hA001;

   localparam logic [BYTE_W-1:0] SYNC_VALUE_RESET    = 8'h00;
   localparam logic [WORD_W-1:0] CRC_START_RESET     = 16'h0000;
   localparam logic [WORD_W-1:0] LENGTH_OFFSET_RESET = 16'h0001;
   localparam logic [WORD_W-1:0] MAX_PAYLOAD_RESET   = 16'h00FF;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SYNC_VALUE    = 2'd0,
      CSR_CRC_START     = 2'd1,
      CSR_LENGTH_OFFSET = 2'd2,
      CSR_MAX_PAYLOAD   = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      PH_SYNC  = 3'd0,
      PH_LEN_L = 3'd1,
      PH_LEN_H = 3'd2,
      PH_CMD   = 3'd3,
      PH_DATA  = 3'd4,
      PH_CRC_L = 3'd5,
      PH_CRC_H = 3'd6
   } phase_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_BUSY  = 2'd0,
      ST_GOOD  = 2'd1,
      ST_ERROR = 2'd2
   } status_type;

   // What the back end does with its CRC register for one item.
   typedef enum logic [1:0] {
      CRC_HOLD  = 2'd0,
      CRC_LOAD  = 2'd1,
      CRC_STEP  = 2'd2,
      CRC_CHECK = 2'd3
   } crc_op_type;

   typedef struct packed {
      logic [BYTE_W-1:0] sync_value;
      logic [WORD_W-1:0] length_offset;
      logic [WORD_W-1:0] max_payload;
   } front_cfg_type;

   typedef struct packed {
      crc_op_type        op;
      logic              length_error;
      logic [BYTE_W-1:0] data;
      logic [BYTE_W-1:0] command;
      logic              payload_valid;
      logic [WORD_W-1:0] payload_index;
   } work_item_type;

   typedef struct packed {
      status_type        status;
      logic [BYTE_W-1:0] command_code;
      logic              payload_valid;
      logic [BYTE_W-1:0] payload_byte;
      logic [WORD_W-1:0] payload_index;
   } result_type;

   function automatic logic [WORD_W-1:0] crc_step(input logic [WORD_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] data);
      logic [WORD_W-1:0] c;
      c = crc ^ {{(WORD_W-BYTE_W){1'b0}}, data};
      for (int k = 0; k < BYTE_W; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

/* hw/rtl/slfp_queue.sv */
// ----------------------------------------------------------------------------
// slfp_queue: short queue of classified items between front and back end
// Register based; push and pop may happen in the same cycle, also when full.
// ----------------------------------------------------------------------------
module slfp_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  slfp_pkg::work_item_type push_item,
   output logic                    full,
   input  logic                    pop,
   output slfp_pkg::work_item_type head,
   output logic                    empty
);

   slfp_pkg::work_item_type              entry_ff [slfp_pkg::QUEUE_DEPTH];
   logic [slfp_pkg::QUEUE_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [slfp_pkg::QUEUE_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [slfp_pkg::QUEUE_CNT_W-1:0]     count_ff, count_in;
   logic                                 do_push, do_pop;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == slfp_pkg::QUEUE_CNT_W'(slfp_pkg::QUEUE_DEPTH));
   assign head    = entry_ff[rd_ptr_ff];
   assign do_pop  = pop && !empty;
   assign do_push = push && (!full || do_pop);

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= slfp_pkg::QUEUE_CNT_W'(slfp_pkg::QUEUE_DEPTH))
      else $error("queue count beyond depth");

   a_count_grow: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count did not advance on push");

endmodule

/* hw/rtl/slfp_front.sv */
// ----------------------------------------------------------------------------
// slfp_front: frame phase tracker
// Walk sync, length, command, payload and CRC phases one byte at a time and
// hand each byte on as a classified item for the CRC back end.
// ----------------------------------------------------------------------------
module slfp_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             accept,
   input  logic [slfp_pkg::BYTE_W-1:0]      rx_byte,
   input  slfp_pkg::front_cfg_type          cfg,
   output slfp_pkg::work_item_type          item
);

   slfp_pkg::phase_type               phase_ff, phase_in;
   logic [slfp_pkg::WORD_W-1:0]       length_ff, length_in;
   logic [slfp_pkg::WORD_W-1:0]       count_ff, count_in;
   logic [slfp_pkg::BYTE_W-1:0]       command_ff, command_in;
   logic [slfp_pkg::WORD_W-1:0]       length_new;
   logic [slfp_pkg::WORD_W:0]         upper_bound;
   logic [slfp_pkg::WORD_W:0]         count_end;

   assign length_new  = {rx_byte, length_ff[slfp_pkg::BYTE_W-1:0]};
   assign upper_bound = {1'b0, cfg.max_payload} + {1'b0, cfg.length_offset};
   assign count_end   = {1'b0, count_ff + 1'b1} + {1'b0, cfg.length_offset};

   always_comb begin
      phase_in           = phase_ff;
      length_in          = length_ff;
      count_in           = count_ff;
      command_in         = command_ff;
      item.op            = slfp_pkg::CRC_HOLD;
      item.length_error  = 1'b0;
      item.data          = rx_byte;
      item.payload_valid = 1'b0;
      item.payload_index = '0;
      if (accept) begin
         case (phase_ff)
            slfp_pkg::PH_LEN_L: begin
               length_in = {{(slfp_pkg::WORD_W-slfp_pkg::BYTE_W){1'b0}}, rx_byte};
               phase_in  = slfp_pkg::PH_LEN_H;
            end
            slfp_pkg::PH_LEN_H: begin
               length_in = length_new;
               if (length_new >= cfg.length_offset && {1'b0, length_new} <= upper_bound) begin
                  phase_in = slfp_pkg::PH_CMD;
               end else begin
                  phase_in          = slfp_pkg::PH_SYNC;
                  item.length_error = 1'b1;
               end
            end
            slfp_pkg::PH_CMD: begin
               item.op    = slfp_pkg::CRC_STEP;
               command_in = rx_byte;
               phase_in   = (length_ff != cfg.length_offset) ? slfp_pkg::PH_DATA
                                                             : slfp_pkg::PH_CRC_L;
            end
            slfp_pkg::PH_DATA: begin
               item.op            = slfp_pkg::CRC_STEP;
               item.payload_valid = 1'b1;
               item.payload_index = count_ff;
               count_in           = count_ff + 1'b1;
               if (count_end >= {1'b0, length_ff}) begin
                  phase_in = slfp_pkg::PH_CRC_L;
               end
            end
            slfp_pkg::PH_CRC_L: begin
               item.op  = slfp_pkg::CRC_STEP;
               phase_in = slfp_pkg::PH_CRC_H;
            end
            slfp_pkg::PH_CRC_H: begin
               item.op  = slfp_pkg::CRC_CHECK;
               phase_in = slfp_pkg::PH_SYNC;
            end
            default: begin
               // hunt; the unused phase code hunts too
               phase_in = slfp_pkg::PH_SYNC;
               if (rx_byte == cfg.sync_value) begin
                  phase_in = slfp_pkg::PH_LEN_L;
                  item.op  = slfp_pkg::CRC_LOAD;
                  count_in = '0;
               end
            end
         endcase
      end
      item.command = command_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= slfp_pkg::PH_SYNC;
         length_ff  <= '0;
         count_ff   <= '0;
         command_ff <= '0;
      end else begin
         phase_ff   <= phase_in;
         length_ff  <= length_in;
         count_ff   <= count_in;
         command_ff <= command_in;
      end
   end

   a_payload_phase: assert property (@(posedge clock) disable iff (reset)
      item.payload_valid |-> (accept && phase_ff == slfp_pkg::PH_DATA))
      else $error("payload item outside payload phase");

endmodule

/* hw/rtl/slfp_back.sv */
// ----------------------------------------------------------------------------
// slfp_back: CRC engine and result queue
// Run the CRC register over classified items, settle the frame status and
// queue results for the output side.
// ----------------------------------------------------------------------------
module slfp_back (
   input  logic                        clock,
   input  logic                        reset,
   input  slfp_pkg::work_item_type     item,
   input  logic                        item_valid,
   output logic                        item_pop,
   input  logic [slfp_pkg::WORD_W-1:0] crc_start,
   input  logic                        rsp_pop,
   output slfp_pkg::result_type        rsp,
   output logic                        rsp_empty
);

   slfp_pkg::result_type              entry_ff [slfp_pkg::QUEUE_DEPTH];
   logic [slfp_pkg::QUEUE_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [slfp_pkg::QUEUE_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [slfp_pkg::QUEUE_CNT_W-1:0]  count_ff, count_in;
   logic [slfp_pkg::WORD_W-1:0]       crc_ff, crc_in;
   logic [slfp_pkg::WORD_W-1:0]       crc_stepped;
   slfp_pkg::result_type              result;
   logic                              out_full, do_pop;

   assign rsp_empty   = (count_ff == '0);
   assign out_full    = (count_ff == slfp_pkg::QUEUE_CNT_W'(slfp_pkg::QUEUE_DEPTH));
   assign rsp         = entry_ff[rd_ptr_ff];
   assign do_pop      = rsp_pop && !rsp_empty;
   assign item_pop    = item_valid && (!out_full || do_pop);
   assign crc_stepped = slfp_pkg::crc_step(crc_ff, item.data);

   always_comb begin
      crc_in                = crc_ff;
      result.status         = slfp_pkg::ST_BUSY;
      result.command_code   = item.command;
      result.payload_valid  = item.payload_valid;
      result.payload_byte   = item.payload_valid ? item.data : '0;
      result.payload_index  = item.payload_index;
      case (item.op)
         slfp_pkg::CRC_LOAD:  crc_in = crc_start;
         slfp_pkg::CRC_STEP:  crc_in = crc_stepped;
         slfp_pkg::CRC_CHECK: begin
            crc_in        = crc_stepped;
            result.status = (crc_stepped == '0) ? slfp_pkg::ST_GOOD : slfp_pkg::ST_ERROR;
         end
         default:             crc_in = crc_ff;
      endcase
      if (item.length_error) begin
         result.status = slfp_pkg::ST_ERROR;
      end
   end

   always_comb begin
      wr_ptr_in = item_pop ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop   ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (item_pop && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !item_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         crc_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         if (item_pop) begin
            crc_ff <= crc_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (item_pop) begin
         entry_ff[wr_ptr_ff] <= result;
      end
   end

   a_payload_busy: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp.payload_valid) |-> (rsp.status == slfp_pkg::ST_BUSY))
      else $error("payload result carries a final status");

endmodule

/* hw/rtl/sync_length_frame_parser_crc16.sv */
// ----------------------------------------------------------------------------
// sync_length_frame_parser_crc16: serial frame deframer with CRC-16 check
// Hunt for a sync byte, check the length field, stream out payload bytes with
// their index and report good or bad CRC at the end of each frame.
// ----------------------------------------------------------------------------
// Usage:
//   Input side is a queue: drive req_rx_byte and raise req_push; an item is
//   taken at each rising edge with req_push high and req_full low.
//   Output side is a queue too: while rsp_empty is low the oldest result sits
//   on the rsp_ ports; raise rsp_pop to take it. Every input item yields
//   exactly one result item (status busy/good/error, command, payload info).
//   A taken item first waits in the middle queue, then the CRC engine writes
//   its result into the result queue, whose head sits on the rsp_ ports;
//   while the result queue is full the item waits in the middle queue.
//   Throughput: one item per cycle while results are popped; the CRC engine
//   does one byte step per cycle; both queues push and pop in the same cycle.
//   Stalls: with rsp_pop low, the result queue fills, then the queue between
//   the phase tracker and the CRC engine fills, and req_full rises after at
//   most four waiting items; nothing is dropped.
//   Reset (synchronous, active high) clears both queues, the parser state to
//   sync hunt, and the registers to their defaults (sync 0x00, CRC start 0,
//   length offset 1, max payload 255). Write registers only while idle.
// ----------------------------------------------------------------------------
module sync_length_frame_parser_crc16 (
   input  logic                              clock,
   input  logic                              reset,
   // input channel
   input  logic                              req_push,
   output logic                              req_full,
   input  logic [slfp_pkg::BYTE_W-1:0]       req_rx_byte,
   // result channel
   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output logic [slfp_pkg::STATUS_W-1:0]     rsp_status,
   output logic [slfp_pkg::BYTE_W-1:0]       rsp_command_code,
   output logic                              rsp_payload_valid,
   output logic [slfp_pkg::BYTE_W-1:0]       rsp_payload_byte,
   output logic [slfp_pkg::WORD_W-1:0]       rsp_payload_index,
   // register write port
   input  logic                              csr_write,
   input  logic [slfp_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [slfp_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   logic [slfp_pkg::BYTE_W-1:0]  sync_value_ff;
   logic [slfp_pkg::WORD_W-1:0]  crc_start_ff;
   logic [slfp_pkg::WORD_W-1:0]  length_offset_ff;
   logic [slfp_pkg::WORD_W-1:0]  max_payload_ff;

   slfp_pkg::front_cfg_type      front_cfg;
   slfp_pkg::work_item_type      front_item;
   slfp_pkg::work_item_type      back_item;
   slfp_pkg::result_type         rsp_item;
   logic                         accept;
   logic                         mid_empty;
   logic                         mid_pop;

   // Register file: plain writes, unknown indexes drop.
   always_ff @(posedge clock) begin
      if (reset) begin
         sync_value_ff    <= slfp_pkg::SYNC_VALUE_RESET;
         crc_start_ff     <= slfp_pkg::CRC_START_RESET;
         length_offset_ff <= slfp_pkg::LENGTH_OFFSET_RESET;
         max_payload_ff   <= slfp_pkg::MAX_PAYLOAD_RESET;
      end else if (csr_write) begin
         case (slfp_pkg::csr_index_type'(csr_index))
            slfp_pkg::CSR_SYNC_VALUE:    sync_value_ff    <= csr_wdata[slfp_pkg::BYTE_W-1:0];
            slfp_pkg::CSR_CRC_START:     crc_start_ff     <= csr_wdata;
            slfp_pkg::CSR_LENGTH_OFFSET: length_offset_ff <= csr_wdata;
            slfp_pkg::CSR_MAX_PAYLOAD:   max_payload_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign front_cfg.sync_value    = sync_value_ff;
   assign front_cfg.length_offset = length_offset_ff;
   assign front_cfg.max_payload   = max_payload_ff;

   // Take an item whenever the middle queue has room.
   assign accept = req_push && !req_full;

   slfp_front u_front (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .rx_byte (req_rx_byte),
      .cfg     (front_cfg),
      .item    (front_item)
   );

   slfp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_item (front_item),
      .full      (req_full),
      .pop       (mid_pop),
      .head      (back_item),
      .empty     (mid_empty)
   );

   slfp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item       (back_item),
      .item_valid (!mid_empty),
      .item_pop   (mid_pop),
      .crc_start  (crc_start_ff),
      .rsp_pop    (rsp_pop),
      .rsp        (rsp_item),
      .rsp_empty  (rsp_empty)
   );

   assign rsp_status        = rsp_item.status;
   assign rsp_command_code  = rsp_item.command_code;
   assign rsp_payload_valid = rsp_item.payload_valid;
   assign rsp_payload_byte  = rsp_item.payload_byte;
   assign rsp_payload_index = rsp_item.payload_index;

endmodule

/* dv/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for sync_length_frame_parser_crc16
// Feeds received bytes through the input queue, predicts every result item
// with a local deframer and CRC-16/ARC model, and checks each popped result
// field by field. A directed table comes first, then random frames under
// several register settings, with random idle cycles on both sides.
// ----------------------------------------------------------------------------
module testbench;

   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASE_ITEMS = 215;
   localparam int PRINT_LIMIT = 40;

   // Directed rows: a plain byte, or a CRC byte worked out when the row is sent.
   typedef enum logic [1:0] {
      ROW_BYTE    = 2'd0,
      ROW_CRC_LO  = 2'd1,
      ROW_CRC_HI  = 2'd2,
      ROW_CRC_BAD = 2'd3
   } row_kind_type;

   typedef struct {
      row_kind_type                kind;
      logic [slfp_pkg::BYTE_W-1:0] data;
      bit                          pinned;
      slfp_pkg::result_type        want;
   } stim_row_type;

   logic                             clock;
   logic                             reset;
   logic                             req_push;
   logic                             req_full;
   logic [slfp_pkg::BYTE_W-1:0]      req_rx_byte;
   logic                             rsp_empty;
   logic                             rsp_pop;
   logic [slfp_pkg::STATUS_W-1:0]    rsp_status;
   logic [slfp_pkg::BYTE_W-1:0]      rsp_command_code;
   logic                             rsp_payload_valid;
   logic [slfp_pkg::BYTE_W-1:0]      rsp_payload_byte;
   logic [slfp_pkg::WORD_W-1:0]      rsp_payload_index;
   logic                             csr_write;
   logic [slfp_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [slfp_pkg::CSR_DATA_W-1:0]  csr_wdata;

   // Local copy of the registers and the deframer state.
   logic [slfp_pkg::BYTE_W-1:0] cfg_sync;
   logic [slfp_pkg::WORD_W-1:0] cfg_crc_start;
   logic [slfp_pkg::WORD_W-1:0] cfg_offset;
   logic [slfp_pkg::WORD_W-1:0] cfg_max;
   slfp_pkg::phase_type         pr_phase;
   logic [slfp_pkg::WORD_W-1:0] pr_crc;
   logic [slfp_pkg::WORD_W-1:0] pr_len;
   logic [slfp_pkg::WORD_W-1:0] pr_count;
   logic [slfp_pkg::BYTE_W-1:0] pr_cmd;

   slfp_pkg::result_type        deframed_q[$];
   stim_row_type                stim_table[$];
   stim_row_type                row;
   slfp_pkg::result_type        want_r;
   logic [slfp_pkg::WORD_W-1:0] crc_held;

   bit calm;
   int error_count;
   int cycle_count;
   int items_total;
   int phase_items;
   int settings_used;
   int frames_good, frames_bad_crc, frames_bad_len, frames_cut;
   int results_checked, ends_good, ends_error, payload_seen;

   sync_length_frame_parser_crc16 u_top (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_rx_byte       (req_rx_byte),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_status        (rsp_status),
      .rsp_command_code  (rsp_command_code),
      .rsp_payload_valid (rsp_payload_valid),
      .rsp_payload_byte  (rsp_payload_byte),
      .rsp_payload_index (rsp_payload_index),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Print one mismatch line (up to a cap) and count it.
   task automatic report(input string what, input logic [63:0] got,
                         input logic [63:0] want);
      error_count++;
      if (error_count <= PRINT_LIMIT)
         $display("[%0t] MISMATCH %s: got %0h, want %0h", $time, what, got, want);
   endtask

   // Reflected CRC-16, one data bit per round, LSB first.
   function automatic logic [slfp_pkg::WORD_W-1:0] crc_arc(
         input logic [slfp_pkg::WORD_W-1:0] c,
         input logic [slfp_pkg::BYTE_W-1:0] d);
      logic fb;
      for (int i = 0; i < slfp_pkg::BYTE_W; i++) begin
         fb = c[0] ^ d[i];
         c  = c >> 1;
         if (fb)
            c = c ^ slfp_pkg::CRC_POLY;
      end
      return c;
   endfunction

   task automatic reset_deframer();
      cfg_sync      = slfp_pkg::SYNC_VALUE_RESET;
      cfg_crc_start = slfp_pkg::CRC_START_RESET;
      cfg_offset    = slfp_pkg::LENGTH_OFFSET_RESET;
      cfg_max       = slfp_pkg::MAX_PAYLOAD_RESET;
      pr_phase      = slfp_pkg::PH_SYNC;
      pr_crc        = '0;
      pr_len        = '0;
      pr_count      = '0;
      pr_cmd        = '0;
   endtask

   // Advance the local deframer by one received byte and return its result.
   function automatic slfp_pkg::result_type deframe_byte(
         input logic [slfp_pkg::BYTE_W-1:0] b);
      slfp_pkg::result_type        r;
      logic [slfp_pkg::WORD_W:0]   bound;
      r = '0;
      r.status = slfp_pkg::ST_BUSY;
      case (pr_phase)
         slfp_pkg::PH_LEN_L: begin
            pr_len   = {8'h00, b};
            pr_phase = slfp_pkg::PH_LEN_H;
         end
         slfp_pkg::PH_LEN_H: begin
            pr_len[15:8] = b;
            // upper bound at 17 bits so it cannot wrap
            bound = {1'b0, cfg_max} + {1'b0, cfg_offset};
            if (pr_len >= cfg_offset && {1'b0, pr_len} <= bound) begin
               pr_phase = slfp_pkg::PH_CMD;
            end else begin
               pr_phase = slfp_pkg::PH_SYNC;
               r.status = slfp_pkg::ST_ERROR;
            end
         end
         slfp_pkg::PH_CMD: begin
            pr_crc   = crc_arc(pr_crc, b);
            pr_cmd   = b;
            pr_phase = (pr_len != cfg_offset) ? slfp_pkg::PH_DATA : slfp_pkg::PH_CRC_L;
         end
         slfp_pkg::PH_DATA: begin
            pr_crc          = crc_arc(pr_crc, b);
            r.payload_valid = 1'b1;
            r.payload_byte  = b;
            r.payload_index = pr_count;
            pr_count        = pr_count + 16'd1;
            if ({1'b0, pr_count} + {1'b0, cfg_offset} >= {1'b0, pr_len})
               pr_phase = slfp_pkg::PH_CRC_L;
         end
         slfp_pkg::PH_CRC_L: begin
            pr_crc   = crc_arc(pr_crc, b);
            pr_phase = slfp_pkg::PH_CRC_H;
         end
         slfp_pkg::PH_CRC_H: begin
            pr_crc   = crc_arc(pr_crc, b);
            pr_phase = slfp_pkg::PH_SYNC;
            r.status = (pr_crc == '0) ? slfp_pkg::ST_GOOD : slfp_pkg::ST_ERROR;
         end
         default: begin
            pr_phase = slfp_pkg::PH_SYNC;
            if (b == cfg_sync) begin
               pr_phase = slfp_pkg::PH_LEN_L;
               pr_crc   = cfg_crc_start;
               pr_count = '0;
            end
         end
      endcase
      r.command_code = pr_cmd;
      return r;
   endfunction

   // Push one byte into the block, idling first now and then, and queue the
   // predicted result once the block takes the item.
   task automatic send_item(input logic [slfp_pkg::BYTE_W-1:0] b, input bit counted);
      @(negedge clock);
      if (!calm && $urandom_range(99) < 18) begin
         req_push <= 1'b0;
         repeat ($urandom_range(3, 1)) @(negedge clock);
      end
      req_push    <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (req_full);
      deframed_q.push_back(deframe_byte(b));
      if (counted) begin
         items_total++;
         phase_items++;
      end
   endtask

   // Hold the sender until every queued result has been popped.
   task automatic drain();
      @(negedge clock);
      req_push <= 1'b0;
      while (deframed_q.size() != 0)
         @(negedge clock);
   endtask

   // Write all four registers back to back; junk in the unused upper bits of
   // the sync write must be ignored.
   task automatic set_regs(input logic [slfp_pkg::BYTE_W-1:0] s,
                           input logic [slfp_pkg::WORD_W-1:0] c0,
                           input logic [slfp_pkg::WORD_W-1:0] off,
                           input logic [slfp_pkg::WORD_W-1:0] mx);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= slfp_pkg::CSR_SYNC_VALUE;
      csr_wdata <= {8'($urandom_range(255)), s};
      @(negedge clock);
      csr_index <= slfp_pkg::CSR_CRC_START;
      csr_wdata <= c0;
      @(negedge clock);
      csr_index <= slfp_pkg::CSR_LENGTH_OFFSET;
      csr_wdata <= off;
      @(negedge clock);
      csr_index <= slfp_pkg::CSR_MAX_PAYLOAD;
      csr_wdata <= mx;
      @(negedge clock);
      csr_write <= 1'b0;
      cfg_sync      = s;
      cfg_crc_start = c0;
      cfg_offset    = off;
      cfg_max       = mx;
      settings_used++;
   endtask

   task automatic add_row(input row_kind_type k, input logic [slfp_pkg::BYTE_W-1:0] b);
      stim_row_type r;
      r.kind   = k;
      r.data   = b;
      r.pinned = 1'b0;
      r.want   = '0;
      stim_table.push_back(r);
   endtask

   task automatic add_pinned(input row_kind_type k, input logic [slfp_pkg::BYTE_W-1:0] b,
                             input slfp_pkg::status_type st,
                             input logic [slfp_pkg::BYTE_W-1:0] cmd,
                             input logic pv, input logic [slfp_pkg::BYTE_W-1:0] pb,
                             input logic [slfp_pkg::WORD_W-1:0] pidx);
      stim_row_type r;
      r.kind                = k;
      r.data                = b;
      r.pinned              = 1'b1;
      r.want                = '0;
      r.want.status         = st;
      r.want.command_code   = cmd;
      r.want.payload_valid  = pv;
      r.want.payload_byte   = pb;
      r.want.payload_index  = pidx;
      stim_table.push_back(r);
   endtask

   // One random frame under the current registers: mostly well formed, with
   // bad CRCs, out-of-range lengths, cut-off frames and line noise mixed in.
   task automatic send_frame();
      int kind, n, lim, len, off, mx;
      logic [slfp_pkg::WORD_W-1:0] held;
      logic [slfp_pkg::BYTE_W-1:0] flip;
      kind = $urandom_range(99);
      off  = int'(cfg_offset);
      mx   = int'(cfg_max);
      if (kind >= 92) begin
         // noise between frames; not counted as stimulus
         repeat ($urandom_range(4, 1)) send_item(8'($urandom_range(255)), 1'b0);
         return;
      end
      if (kind >= 74 && kind < 84 && (off > 0 || off + mx < 65535)) begin
         if (off > 0 && (off + mx >= 65535 || $urandom_range(1)))
            len = $urandom_range(off - 1, 0);
         else
            len = $urandom_range(65535, off + mx + 1);
         send_item(cfg_sync, 1'b1);
         send_item(len[7:0], 1'b1);
         send_item(len[15:8], 1'b1);
         frames_bad_len++;
         return;
      end
      // keep most payloads short; now and then go long where allowed
      lim = mx;
      if (65535 - off < lim)
         lim = 65535 - off;
      n = $urandom_range(lim < 12 ? lim : 12, 0);
      if ($urandom_range(99) < 4)
         n = $urandom_range(lim < 300 ? lim : 300, 0);
      len = off + n;
      send_item(cfg_sync, 1'b1);
      send_item(len[7:0], 1'b1);
      send_item(len[15:8], 1'b1);
      if (kind >= 84) begin
         // cut the frame short after a few bytes
         repeat ($urandom_range(3, 1)) send_item(8'($urandom_range(255)), 1'b1);
         frames_cut++;
         return;
      end
      send_item(8'($urandom_range(255)), 1'b1);
      repeat (n) send_item(8'($urandom_range(255)), 1'b1);
      // append the running CRC low byte first so the residue comes out zero
      held = pr_crc;
      flip = '0;
      if (kind >= 62) begin
         flip = 8'($urandom_range(255, 1));
         frames_bad_crc++;
      end else begin
         frames_good++;
      end
      if ($urandom_range(1)) begin
         send_item(held[7:0] ^ flip, 1'b1);
         send_item(held[15:8], 1'b1);
      end else begin
         send_item(held[7:0], 1'b1);
         send_item(held[15:8] ^ flip, 1'b1);
      end
   endtask

   // Result side: pop at random, with rare long stalls so the input queue
   // fills up and req_full rises.
   initial begin
      rsp_pop = 1'b0;
      forever begin
         @(negedge clock);
         if (!calm && $urandom_range(99) < 2) begin
            rsp_pop <= 1'b0;
            repeat ($urandom_range(12, 6)) @(negedge clock);
         end else begin
            rsp_pop <= calm || ($urandom_range(99) >= 18);
         end
      end
   end

   // Check every popped result against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         if (deframed_q.size() == 0) begin
            report("result with nothing pending", rsp_status, 0);
         end else begin
            want_r = deframed_q.pop_front();
            results_checked++;
            if (rsp_status !== want_r.status)
               report("status", rsp_status, want_r.status);
            if (rsp_command_code !== want_r.command_code)
               report("command_code", rsp_command_code, want_r.command_code);
            if (rsp_payload_valid !== want_r.payload_valid)
               report("payload_valid", rsp_payload_valid, want_r.payload_valid);
            if (rsp_payload_byte !== want_r.payload_byte)
               report("payload_byte", rsp_payload_byte, want_r.payload_byte);
            if (rsp_payload_index !== want_r.payload_index)
               report("payload_index", rsp_payload_index, want_r.payload_index);
            if (want_r.status == slfp_pkg::ST_GOOD)
               ends_good++;
            if (want_r.status == slfp_pkg::ST_ERROR)
               ends_error++;
            if (want_r.payload_valid)
               payload_seen++;
         end
      end
   end

   // Watchdog: a hung run ends here.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timeout after %0d cycles, %0d results still pending",
               cycle_count, deframed_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      clock       = 1'b0;
      reset       = 1'b1;
      req_push    = 1'b0;
      req_rx_byte = '0;
      csr_write   = 1'b0;
      csr_index   = slfp_pkg::CSR_SYNC_VALUE;
      csr_wdata   = '0;
      calm        = 1'b0;
      reset_deframer();

      // Directed table, register defaults: sync 0x00, offset 1, max 255.
      // hunting on a non-sync byte
      add_pinned(ROW_BYTE, 8'hFF, slfp_pkg::ST_BUSY, 8'h00, 1'b0, 8'h00, 16'h0000);
      // length 0 is below the offset
      add_pinned(ROW_BYTE, 8'h00, slfp_pkg::ST_BUSY, 8'h00, 1'b0, 8'h00, 16'h0000);
      add_row(ROW_BYTE, 8'h00);
      add_pinned(ROW_BYTE, 8'h00, slfp_pkg::ST_ERROR, 8'h00, 1'b0, 8'h00, 16'h0000);
      // length 257 is one above max payload plus offset
      add_row(ROW_BYTE, 8'h00);
      add_row(ROW_BYTE, 8'h01);
      add_pinned(ROW_BYTE, 8'h01, slfp_pkg::ST_ERROR, 8'h00, 1'b0, 8'h00, 16'h0000);
      // empty payload: command straight into the CRC, which is good
      add_row(ROW_BYTE, 8'h00);
      add_row(ROW_BYTE, 8'h01);
      add_row(ROW_BYTE, 8'h00);
      add_pinned(ROW_BYTE, 8'hFF, slfp_pkg::ST_BUSY, 8'hFF, 1'b0, 8'h00, 16'h0000);
      add_row(ROW_CRC_LO, 8'h00);
      add_pinned(ROW_CRC_HI, 8'h00, slfp_pkg::ST_GOOD, 8'hFF, 1'b0, 8'h00, 16'h0000);
      // two payload bytes at the byte extremes, then a bad CRC
      add_row(ROW_BYTE, 8'h00);
      add_row(ROW_BYTE, 8'h03);
      add_row(ROW_BYTE, 8'h00);
      add_pinned(ROW_BYTE, 8'h5A, slfp_pkg::ST_BUSY, 8'h5A, 1'b0, 8'h00, 16'h0000);
      add_pinned(ROW_BYTE, 8'hFF, slfp_pkg::ST_BUSY, 8'h5A, 1'b1, 8'hFF, 16'h0000);
      add_pinned(ROW_BYTE, 8'h00, slfp_pkg::ST_BUSY, 8'h5A, 1'b1, 8'h00, 16'h0001);
      add_row(ROW_CRC_LO, 8'h00);
      add_pinned(ROW_CRC_BAD, 8'h00, slfp_pkg::ST_ERROR, 8'h5A, 1'b0, 8'h00, 16'h0000);
      // largest allowed length is accepted; the last command byte still shows
      add_row(ROW_BYTE, 8'h00);
      add_row(ROW_BYTE, 8'h00);
      add_pinned(ROW_BYTE, 8'h01, slfp_pkg::ST_BUSY, 8'h5A, 1'b0, 8'h00, 16'h0000);

      repeat (7) @(negedge clock);
      reset <= 1'b0;

      foreach (stim_table[i]) begin
         row = stim_table[i];
         case (row.kind)
            ROW_CRC_LO: begin
               crc_held = pr_crc;
               row.data = crc_held[7:0];
            end
            ROW_CRC_HI:  row.data = crc_held[15:8];
            ROW_CRC_BAD: row.data = crc_held[15:8] ^ 8'h80;
            default: ;
         endcase
         send_item(row.data, 1'b1);
         if (row.pinned) begin
            // the typed value is what gets checked; flag a disagreeing model
            if (deframed_q[$] !== row.want)
               report("directed row vs model", deframed_q[$], row.want);
            deframed_q[deframed_q.size() - 1] = row.want;
         end
      end
      drain();

      // Random phases, each under its own register setting; drain before
      // every register write so the block is idle.
      for (int p = 0; p < 6; p++) begin
         case (p)
            0: set_regs(8'h7E, 16'hFFFF, 16'd2, 16'd16);
            1: set_regs(8'h00, 16'h0000, 16'd0, 16'd0);
            2: set_regs(8'hFF, 16'($urandom_range(16'hFFFF)), 16'd1, 16'hFFFF);
            3: set_regs(8'($urandom_range(255)), 16'($urandom_range(16'hFFFF)),
                        16'hFFFF, 16'hFFFF);
            4: set_regs(8'($urandom_range(255)), 16'($urandom_range(16'hFFFF)),
                        16'hFFF0, 16'd32);
            default: set_regs(8'($urandom_range(255)), 16'($urandom_range(16'hFFFF)),
                              16'($urandom_range(8)), 16'($urandom_range(40)));
         endcase
         // run one whole phase with no idling on either side
         calm = (p == 2);
         phase_items = 0;
         while (phase_items < PHASE_ITEMS)
            send_frame();
         drain();
      end
      calm = 1'b0;

      // let any stray result show up before the verdict
      repeat (20) @(posedge clock);

      $display("Sent %0d items in %0d register settings: %0d good frames, %0d bad CRC,",
               items_total, settings_used, frames_good, frames_bad_crc);
      $display("%0d bad length, %0d cut short; checked %0d results (%0d good, %0d error)",
               frames_bad_len, frames_cut, results_checked, ends_good, ends_error);
      $display("Payload bytes seen: %0d", payload_seen);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
